// ----- hdl/tcp_pkg.sv -----
package tcp_pkg;

  // One in Q16.16.
  localparam logic [30:0] Q_ONE = 31'd65536;

  // Largest value of the 31-bit magnitude field.
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MIN_MAG  = 2'd0;
  localparam logic [1:0] REG_TILT_TAN = 2'd1;
  localparam logic [1:0] REG_MAX_MAG  = 2'd2;

  // Reset values of the registers.
  localparam logic [30:0] MIN_MAG_RST  = 31'd65536;
  localparam logic [30:0] TILT_TAN_RST = 31'd65536;
  localparam logic [30:0] MAX_MAG_RST  = 31'd655360000;

  // A vector held as sign and magnitude; the vertical part is always positive.
  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [31:0] mx;
    logic [31:0] my;
    logic [30:0] z;
  } vec_t;

  // Carried through the first square root: the vector and the cone limit.
  typedef struct packed {
    vec_t        v;
    logic [45:0] maxh;
  } cone_t;

  // Carried through the cone divider.
  typedef struct packed {
    vec_t v;
    logic scale;
  } scl_t;

  // Carried through the magnitude divider.
  typedef struct packed {
    vec_t        v;
    logic        scale;
    logic [31:0] norm;
  } nrm_t;

endpackage

// ----- hdl/thrust_cone_projection_top.sv -----
// Channel  | Direction | Contents (lowest bit first)
// s_axis   | in        | tdata: req_x[31:0], req_y[63:32], req_z[95:64]
// m_axis   | out       | tdata: out_x[31:0], out_y[63:32], out_z[95:64],
//          |           |        magnitude[126:96], zero[127]
// cfg      | in        | cfg_we, cfg_index (0 min, 1 tilt tangent, 2 max), cfg_data
//
// One word enters per cycle while m_axis is not stalled; each result passes through
// two 32-stage square roots and two 32-stage dividers in series.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
module thrust_cone_projection_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // req_x, req_y, req_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_x, out_y, out_z, magnitude, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  logic        en;
  logic [30:0] min_mag;
  logic [30:0] tilt_tan;
  logic [30:0] max_mag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_mag  <= tcp_pkg::MIN_MAG_RST;
      tilt_tan <= tcp_pkg::TILT_TAN_RST;
      max_mag  <= tcp_pkg::MAX_MAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcp_pkg::REG_MIN_MAG:  min_mag  <= cfg_data;
        tcp_pkg::REG_TILT_TAN: tilt_tan <= cfg_data;
        tcp_pkg::REG_MAX_MAG:  max_mag  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: sign and magnitude; a non-positive vertical part points straight up.
  logic          a_vld;
  tcp_pkg::vec_t a_v;
  tcp_pkg::vec_t a_v_next;
  logic [31:0]   in_x;
  logic [31:0]   in_y;
  logic [31:0]   in_z;

  assign in_x = s_axis_tdata[31:0];
  assign in_y = s_axis_tdata[63:32];
  assign in_z = s_axis_tdata[95:64];

  always_comb begin
    if (!in_z[31] && (in_z != '0)) begin
      a_v_next.sx = in_x[31];
      a_v_next.sy = in_y[31];
      a_v_next.mx = in_x[31] ? 32'(~in_x + 32'd1) : in_x;
      a_v_next.my = in_y[31] ? 32'(~in_y + 32'd1) : in_y;
      a_v_next.z  = in_z[30:0];
    end else begin
      a_v_next.sx = 1'b0;
      a_v_next.sy = 1'b0;
      a_v_next.mx = '0;
      a_v_next.my = '0;
      a_v_next.z  = (min_mag > tcp_pkg::Q_ONE) ? min_mag : tcp_pkg::Q_ONE;
    end
  end

  // Stage B: horizontal squares and the cone limit.
  logic          b_vld;
  tcp_pkg::vec_t b_v;
  logic [63:0]   b_px;
  logic [63:0]   b_py;
  logic [61:0]   b_zt;

  // Stage C: horizontal sum of squares.
  logic          c_vld;
  logic [63:0]   c_sum;
  tcp_pkg::cone_t c_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v        <= a_v_next;
      b_v        <= a_v;
      b_px       <= a_v.mx * a_v.mx;
      b_py       <= a_v.my * a_v.my;
      b_zt       <= a_v.z * tilt_tan;
      c_sum      <= b_px + b_py;
      c_pay.v    <= b_v;
      c_pay.maxh <= b_zt[61:16];
    end
  end

  // Horizontal magnitude.
  logic           h_vld;
  logic [31:0]    h_root;
  tcp_pkg::cone_t h_pay;

  tcp_sqrt #(.PW($bits(tcp_pkg::cone_t))) u_sqrt_h (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (c_vld),
    .in_rad   (c_sum),
    .in_pay   (c_pay),
    .out_vld  (h_vld),
    .out_root (h_root),
    .out_pay  (h_pay)
  );

  // Stage D: decide on cone scaling and form the numerators.
  logic              d_vld;
  logic [1:0][63:0]  d_num;
  logic [31:0]       d_den;
  tcp_pkg::scl_t     d_pay;
  logic              d_scale;

  assign d_scale = ({14'd0, h_root} > h_pay.maxh) && (h_root != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num[0]    <= h_pay.v.mx * h_pay.maxh[31:0];
      d_num[1]    <= h_pay.v.my * h_pay.maxh[31:0];
      d_den       <= h_root;
      d_pay.v     <= h_pay.v;
      d_pay.scale <= d_scale;
    end
  end

  logic             q1_vld;
  logic [1:0][31:0] q1_quo;
  tcp_pkg::scl_t    q1_pay;

  tcp_div #(.LANES(2), .PW($bits(tcp_pkg::scl_t))) u_div_cone (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .in_num  (d_num),
    .in_den  (d_den),
    .in_pay  (d_pay),
    .out_vld (q1_vld),
    .out_quo (q1_quo),
    .out_pay (q1_pay)
  );

  // Stage E: apply the cone scaling.
  logic          e_vld;
  tcp_pkg::vec_t e_v;

  // Stage F: squares of all three parts.
  logic          f_vld;
  tcp_pkg::vec_t f_v;
  logic [63:0]   f_px;
  logic [63:0]   f_py;
  logic [61:0]   f_pz;

  // Stage G: total sum of squares.
  logic          g_vld;
  tcp_pkg::vec_t g_v;
  logic [63:0]   g_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      e_vld <= q1_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_v.sx <= q1_pay.v.sx;
      e_v.sy <= q1_pay.v.sy;
      e_v.mx <= q1_pay.scale ? q1_quo[0] : q1_pay.v.mx;
      e_v.my <= q1_pay.scale ? q1_quo[1] : q1_pay.v.my;
      e_v.z  <= q1_pay.v.z;
      f_v    <= e_v;
      f_px   <= e_v.mx * e_v.mx;
      f_py   <= e_v.my * e_v.my;
      f_pz   <= e_v.z * e_v.z;
      g_v    <= f_v;
      g_sum  <= f_px + f_py + {2'b00, f_pz};
    end
  end

  // Total magnitude.
  logic          n_vld;
  logic [31:0]   n_root;
  tcp_pkg::vec_t n_pay;

  tcp_sqrt #(.PW($bits(tcp_pkg::vec_t))) u_sqrt_n (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (g_vld),
    .in_rad   (g_sum),
    .in_pay   (g_v),
    .out_vld  (n_vld),
    .out_root (n_root),
    .out_pay  (n_pay)
  );

  // Stage H: decide on the maximum clamp and form the numerators.
  logic             hh_vld;
  logic [2:0][63:0] hh_num;
  logic [31:0]      hh_den;
  tcp_pkg::nrm_t    hh_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      hh_vld <= 1'b0;
    end else if (en) begin
      hh_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_num[0]    <= n_pay.mx * max_mag;
      hh_num[1]    <= n_pay.my * max_mag;
      hh_num[2]    <= n_pay.z * max_mag;
      hh_den       <= n_root;
      hh_pay.v     <= n_pay;
      hh_pay.scale <= (n_root > {1'b0, max_mag});
      hh_pay.norm  <= n_root;
    end
  end

  logic             q2_vld;
  logic [2:0][31:0] q2_quo;
  tcp_pkg::nrm_t    q2_pay;

  tcp_div #(.LANES(3), .PW($bits(tcp_pkg::nrm_t))) u_div_mag (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (hh_vld),
    .in_num  (hh_num),
    .in_den  (hh_den),
    .in_pay  (hh_pay),
    .out_vld (q2_vld),
    .out_quo (q2_quo),
    .out_pay (q2_pay)
  );

  // Output stage: maximum clamp, minimum clamp, signs and saturation.
  logic [31:0] o_mx;
  logic [31:0] o_my;
  logic [31:0] o_mz;
  logic [31:0] o_nrm;
  logic [31:0] o_x;
  logic [31:0] o_y;
  logic [30:0] o_mag;

  always_comb begin
    if (q2_pay.scale) begin
      o_mx  = q2_quo[0];
      o_my  = q2_quo[1];
      o_mz  = q2_quo[2];
      o_nrm = {1'b0, max_mag};
    end else begin
      o_mx  = q2_pay.v.mx;
      o_my  = q2_pay.v.my;
      o_mz  = {1'b0, q2_pay.v.z};
      o_nrm = q2_pay.norm;
    end
    if (o_nrm < {1'b0, min_mag}) begin
      o_mx  = '0;
      o_my  = '0;
      o_mz  = {1'b0, min_mag};
      o_nrm = {1'b0, min_mag};
    end
    o_x   = q2_pay.v.sx ? 32'(~o_mx + 32'd1) : o_mx;
    o_y   = q2_pay.v.sy ? 32'(~o_my + 32'd1) : o_my;
    o_mag = o_nrm[31] ? tcp_pkg::MAG_MAX : o_nrm[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= q2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {1'b0, o_mag, o_mz, o_y, o_x};
    end
  end

endmodule

// ----- hdl/tcp_sqrt.sv -----
// Pipelined floor square root of a 64-bit value, one root bit per stage.
module tcp_sqrt #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);

  localparam int NS = 32;

  logic [NS-1:0] vld;
  logic [63:0]   rad  [NS];
  logic [32:0]   rem  [NS];
  logic [31:0]   root [NS];
  logic [PW-1:0] pay  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          v_i;
    logic [63:0]   rad_i;
    logic [32:0]   rem_i;
    logic [31:0]   root_i;
    logic [PW-1:0] pay_i;
    logic [34:0]   r2;
    logic [34:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_i    = in_vld;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign rad_i  = rad[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign pay_i  = pay[k-1];
    end

    // Bring down the next two bits and try the next root bit.
    assign r2    = {rem_i, rad_i[63:62]};
    assign trial = {1'b0, root_i, 2'b01};
    assign take  = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= {rad_i[61:0], 2'b00};
        rem[k]  <= take ? 33'(r2 - trial) : r2[32:0];
        root[k] <= {root_i[30:0], take};
        pay[k]  <= pay_i;
      end
    end
  end

  assign out_vld  = vld[NS-1];
  assign out_root = root[NS-1];
  assign out_pay  = pay[NS-1];

endmodule

// ----- hdl/tcp_div.sv -----
// Pipelined restoring divider: 64-bit numerators over one shared 32-bit
// denominator, one quotient bit per stage. The quotient must fit 32 bits.
module tcp_div #(
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [LANES-1:0][63:0] in_num,
  input  logic [31:0]            in_den,
  input  logic [PW-1:0]          in_pay,
  output logic                   out_vld,
  output logic [LANES-1:0][31:0] out_quo,
  output logic [PW-1:0]          out_pay
);

  localparam int NS = 32;

  logic [NS-1:0]          vld;
  logic [31:0]            den  [NS];
  logic [PW-1:0]          pay  [NS];
  logic [LANES-1:0][31:0] rem  [NS];
  logic [LANES-1:0][31:0] bits [NS];
  logic [LANES-1:0][31:0] quo  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                   v_i;
    logic [31:0]            d_i;
    logic [PW-1:0]          p_i;
    logic [LANES-1:0][31:0] r_i;
    logic [LANES-1:0][31:0] b_i;
    logic [LANES-1:0][31:0] q_i;
    logic [LANES-1:0][31:0] r_n;
    logic [LANES-1:0][31:0] b_n;
    logic [LANES-1:0][31:0] q_n;

    if (k == 0) begin : g_first
      assign v_i = in_vld;
      assign d_i = in_den;
      assign p_i = in_pay;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign r_i[l] = in_num[l][63:32];
        assign b_i[l] = in_num[l][31:0];
        assign q_i[l] = '0;
      end
    end else begin : g_next
      assign v_i = vld[k-1];
      assign d_i = den[k-1];
      assign p_i = pay[k-1];
      assign r_i = rem[k-1];
      assign b_i = bits[k-1];
      assign q_i = quo[k-1];
    end

    // Shift in one numerator bit per lane and subtract where it fits.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [32:0] r2;
      logic        take;
      assign r2     = {r_i[l], b_i[l][31]};
      assign take   = (r2 >= {1'b0, d_i});
      assign r_n[l] = take ? 32'(r2 - {1'b0, d_i}) : r2[31:0];
      assign b_n[l] = {b_i[l][30:0], 1'b0};
      assign q_n[l] = {q_i[l][30:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[k]  <= d_i;
        pay[k]  <= p_i;
        rem[k]  <= r_n;
        bits[k] <= b_n;
        quo[k]  <= q_n;
      end
    end
  end

  assign out_vld = vld[NS-1];
  assign out_quo = quo[NS-1];
  assign out_pay = pay[NS-1];

endmodule

// ----- tb/thrust_cone_projection_top_test.sv -----
`timescale 1ns / 1ps

module thrust_cone_projection_top_test;

  // One requested thrust vector.
  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } thrust_req_t;

  // One projected thrust vector and its norm.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] mag;
  } thrust_out_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // req_x, req_y, req_z
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // out_x, out_y, out_z, magnitude, zero pad
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;

  thrust_cone_projection_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the limit registers.
  logic [63:0] lim_min, lim_tilt, lim_max;

  thrust_req_t  pending_reqs[$];
  thrust_out_t  expected_vecs[$];
  int           send_idle_pct, recv_stall_pct;
  int           errors;
  bit           hold_start = 1'b0;
  bit           hold_active;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Floor square root of a 64-bit value.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] c);
    return c < 0 ? -c : c;
  endfunction

  // Scales a component by num/den with truncation toward zero.
  function automatic logic signed [63:0] scale_toward_zero(logic signed [63:0] c,
                                                           logic [63:0] num,
                                                           logic [63:0] den);
    logic [63:0] q;
    q = abs64(c) * num / den;
    return c < 0 ? -$signed(q) : $signed(q);
  endfunction

  // Projects a requested vector onto the tilt cone and the magnitude limits.
  function automatic thrust_out_t predict_vector(thrust_req_t r);
    logic signed [63:0] x, y, z;
    logic [63:0] mx, my, h, maxh, norm;
    thrust_out_t o;
    x = $signed(r.x);
    y = $signed(r.y);
    z = $signed(r.z);
    if (z <= 0) begin
      x = 0;
      y = 0;
      z = lim_min > 64'd65536 ? lim_min : 64'd65536;
    end
    mx = abs64(x);
    my = abs64(y);
    h = floor_sqrt(mx * mx + my * my);
    maxh = (z * lim_tilt) >> 16;
    if (h > maxh && h > 0) begin
      x = scale_toward_zero(x, maxh, h);
      y = scale_toward_zero(y, maxh, h);
    end
    mx = abs64(x);
    my = abs64(y);
    norm = floor_sqrt(mx * mx + my * my + z * z);
    if (norm > lim_max) begin
      x = scale_toward_zero(x, lim_max, norm);
      y = scale_toward_zero(y, lim_max, norm);
      z = scale_toward_zero(z, lim_max, norm);
      norm = lim_max;
    end
    if (norm < lim_min) begin
      x = 0;
      y = 0;
      z = lim_min;
      norm = lim_min;
    end
    if (norm > 64'h7FFF_FFFF) norm = 64'h7FFF_FFFF;
    o.x = x[31:0];
    o.y = y[31:0];
    o.z = z[31:0];
    o.mag = norm[30:0];
    return o;
  endfunction

  // Driver: presents the oldest pending word, with random idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vecs.insert(expected_vecs.size(),
                             predict_vector(pending_reqs.pop_front()));
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        // The popped front was consumed above, so the next is at the front.
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_reqs[0];
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted in its own process once started.
  initial begin
    hold_active = 1'b0;
    wait (hold_start);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk) begin
    thrust_out_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_vecs.size() == 0) begin
          $error("result word with no expectation: %h", m_axis_tdata);
          errors++;
        end else begin
          e = expected_vecs.pop_front();
          if (m_axis_tdata[31:0] !== e.x) begin
            $error("out_x expected %h actual %h", e.x, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[63:32] !== e.y) begin
            $error("out_y expected %h actual %h", e.y, m_axis_tdata[63:32]);
            errors++;
          end
          if (m_axis_tdata[95:64] !== e.z) begin
            $error("out_z expected %h actual %h", e.z, m_axis_tdata[95:64]);
            errors++;
          end
          if (m_axis_tdata[126:96] !== e.mag) begin
            $error("magnitude expected %h actual %h", e.mag, m_axis_tdata[126:96]);
            errors++;
          end
        end
      end
      if (hold_active) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  task automatic write_limit(logic [1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tcp_pkg::REG_MIN_MAG:  lim_min  = val;
      tcp_pkg::REG_TILT_TAN: lim_tilt = val;
      default:               lim_max  = val;
    endcase
  endtask

  // Waits until every queued word has gone through and the block is empty.
  task automatic drain_block();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_vecs.size() > 0)
      @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0010_0000);
      2: return -$signed($urandom_range(32'h0010_0000));
      3: return $urandom_range(32'h7FFF_FFFF, 32'h7FF0_0000);
      default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  task automatic queue_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    thrust_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_random(int n);
    logic [31:0] z;
    for (int i = 0; i < n; i++) begin
      // Mostly positive vertical parts so the cone and clamps are reached.
      z = rand_comp();
      if ($urandom_range(9) < 8) z[31] = 1'b0;
      queue_req(rand_comp(), rand_comp(), z);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tcp_pkg::REG_MIN_MAG;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    lim_min = tcp_pkg::MIN_MAG_RST;
    lim_tilt = tcp_pkg::TILT_TAN_RST;
    lim_max = tcp_pkg::MAX_MAG_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, non-positive vertical, zero horizontal, cone and clamps.
    queue_req(32'h0, 32'h0, 32'h0);
    queue_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    queue_req(32'h0, 32'h0, 32'h0001_0000);
    queue_req(32'h0, 32'h0, 32'h7FFF_FFFF);
    queue_req(32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000);
    queue_req(32'h0000_8000, 32'h0, 32'h0000_0100);
    queue_req(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    queue_req(32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001);
    drain_block();

    // Zero tilt, max below min, then extreme limits.
    write_limit(tcp_pkg::REG_TILT_TAN, 31'd0);
    write_limit(tcp_pkg::REG_MIN_MAG, 31'd200000);
    write_limit(tcp_pkg::REG_MAX_MAG, 31'd100000);
    queue_req(32'h0005_0000, 32'h0002_0000, 32'h0004_0000);
    queue_req(32'h0, 32'h0, 32'h0000_1000);
    queue_req(32'h0, 32'h0, 32'h8000_0000);
    queue_random(40);
    drain_block();
    write_limit(tcp_pkg::REG_MIN_MAG, 31'd0);
    write_limit(tcp_pkg::REG_TILT_TAN, 31'h7FFF_FFFF);
    write_limit(tcp_pkg::REG_MAX_MAG, 31'h7FFF_FFFF);
    queue_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_random(160);
    drain_block();

    // Phases of idling under a middling setting.
    write_limit(tcp_pkg::REG_MIN_MAG, 31'd65536);
    write_limit(tcp_pkg::REG_TILT_TAN, 31'd45000);
    write_limit(tcp_pkg::REG_MAX_MAG, 31'd3000000);
    send_idle_pct = 84;
    queue_random(200);
    drain_block();
    send_idle_pct = 0;
    recv_stall_pct = 84;
    queue_random(200);
    drain_block();
    send_idle_pct = 9;
    recv_stall_pct = 9;
    hold_start = 1'b1;
    queue_random(250);
    drain_block();

    // Back to reset values, mixed random limits.
    write_limit(tcp_pkg::REG_MIN_MAG, tcp_pkg::MIN_MAG_RST);
    write_limit(tcp_pkg::REG_TILT_TAN, 31'($urandom_range(32'h0004_0000)));
    write_limit(tcp_pkg::REG_MAX_MAG, tcp_pkg::MAX_MAG_RST);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    queue_random(240);
    drain_block();

    if (errors == 0 && expected_vecs.size() == 0) begin
      $display("[thrust_cone_projection_top] OK");
    end else begin
      $display("[thrust_cone_projection_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[thrust_cone_projection_top] ERROR");
    $finish;
  end

endmodule
